[rtl/vrfs_pkg.sv]
// ----------------------------------------------------------------------------
// Virtual runtime fair scheduler package
// Shared types, codes and helper functions for the scheduler block.
// ----------------------------------------------------------------------------
package vrfs_pkg;

    // Default size of the task table.
    localparam int NUM_TASKS_DEF = 64;

    // Field widths fixed by the interface.
    localparam int OPCODE_W = 3;
    localparam int TID_W    = 6;
    localparam int TIME_W   = 64;
    localparam int SEQ_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int NS_W     = 30;
    localparam int PERIOD_W = NS_W + COUNT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Opcodes carried by an input transaction.
    localparam logic [OPCODE_W-1:0] OP_ENQ    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQ    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PICK   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CHARGE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PLACE  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SLICE  = 3'd5;

    // Command kinds after classification by the front end.
    localparam logic [2:0] K_ENQ    = 3'd0;
    localparam logic [2:0] K_DEQ    = 3'd1;
    localparam logic [2:0] K_PICK   = 3'd2;
    localparam logic [2:0] K_CHARGE = 3'd3;
    localparam logic [2:0] K_PLACE  = 3'd4;
    localparam logic [2:0] K_SLICE  = 3'd5;
    localparam logic [2:0] K_NOP    = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOEFF  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GRAN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_LIMIT = 2'd2;

    // Configuration reset values.
    localparam logic [NS_W-1:0]    LATENCY_RST    = 30'd24000000;
    localparam logic [NS_W-1:0]    MIN_GRAN_RST   = 30'd3000000;
    localparam logic [COUNT_W-1:0] TASK_LIMIT_RST = 7'd8;

    typedef struct packed {
        logic [NS_W-1:0]    latency_ns;
        logic [NS_W-1:0]    min_granularity_ns;
        logic [COUNT_W-1:0] latency_task_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TID_W-1:0]  tid;
        logic [TIME_W-1:0] now_ns;
        logic              initial_placement;
        logic              current_runnable;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                picked_valid;
        logic [TID_W-1:0]    picked_task;
        logic [TIME_W-1:0]   task_vruntime;
        logic [TIME_W-1:0]   floor_vruntime;
        logic [COUNT_W-1:0]  queued_count;
        logic [NS_W-1:0]     slice_ns;
    } t_result;

    // Wrap-safe ordering of vruntimes: a lies before b.
    function automatic logic vr_before(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

    // Wrap-safe ordering of insertion stamps.
    function automatic logic seq_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

endpackage

[rtl/virtual_runtime_fair_scheduler.sv]
// ----------------------------------------------------------------------------
// Virtual runtime fair scheduler
// Fair task scheduler over a fixed table of task slots.
// ----------------------------------------------------------------------------
// Each transaction returns exactly one result. Pick and charge scan every
// task slot through the vruntime RAM read port, one slot per cycle; charge
// first updates the table and afterwards forms a floor candidate. Slice runs
// a bit-serial divider over the 37-bit period. A stall on the result side
// holds a finished result until it is taken. A two-entry queue accepts new
// transactions while the engine works, and the result register lets the next
// transaction start while a result waits to be taken. The table needs no
// clearing after reset. Configuration writes are taken in every cycle and
// must happen while the block is idle.
module virtual_runtime_fair_scheduler import vrfs_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [TID_W-1:0]      i_task_id,
    input  logic [TIME_W-1:0]     i_now_ns,
    input  logic                  i_initial_placement,
    input  logic                  i_current_runnable,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_picked_valid,
    output logic [TID_W-1:0]      o_picked_task,
    output logic [TIME_W-1:0]     o_task_vruntime,
    output logic [TIME_W-1:0]     o_floor_vruntime,
    output logic [COUNT_W-1:0]    o_queued_count,
    output logic [NS_W-1:0]       o_slice_ns,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd    head;
    logic    head_valid;
    logic    pop;
    t_result res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.latency_ns <= LATENCY_RST;
            r_cfg.min_granularity_ns <= MIN_GRAN_RST;
            r_cfg.latency_task_limit <= TASK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LATENCY:    r_cfg.latency_ns <= i_cfg_data[NS_W-1:0];
                CFG_MIN_GRAN:   r_cfg.min_granularity_ns <= i_cfg_data[NS_W-1:0];
                CFG_TASK_LIMIT: r_cfg.latency_task_limit <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    vrfs_front #(.NUM_TASKS(NUM_TASKS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_task_id(i_task_id), .i_now_ns(i_now_ns),
        .i_initial_placement(i_initial_placement),
        .i_current_runnable(i_current_runnable),
        .o_head(head), .o_head_valid(head_valid), .i_pop(pop)
    );

    vrfs_engine #(.NUM_TASKS(NUM_TASKS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_head(head), .i_head_valid(head_valid), .o_pop(pop),
        .i_cfg(r_cfg), .i_out_stall(i_stall),
        .o_res(res), .o_res_valid(o_valid)
    );

    assign o_status = res.status;
    assign o_picked_valid = res.picked_valid;
    assign o_picked_task = res.picked_task;
    assign o_task_vruntime = res.task_vruntime;
    assign o_floor_vruntime = res.floor_vruntime;
    assign o_queued_count = res.queued_count;
    assign o_slice_ns = res.slice_ns;

endmodule

[rtl/vrfs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vrfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/vrfs_front.sv]
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts input transactions, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module vrfs_front import vrfs_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [TID_W-1:0]    i_task_id,
    input  logic [TIME_W-1:0]   i_now_ns,
    input  logic                i_initial_placement,
    input  logic                i_current_runnable,
    output t_cmd                o_head,
    output logic                o_head_valid,
    input  logic                i_pop
);

    localparam int DEPTH = 2;

    t_cmd        r_q [DEPTH];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    t_cmd        cmd;
    logic        in_range;
    logic        push;

    // Classify the opcode; slot operations out of range do nothing.
    always_comb begin
        in_range = (32'(i_task_id) < 32'(NUM_TASKS));
        cmd.tid = i_task_id;
        cmd.now_ns = i_now_ns;
        cmd.initial_placement = i_initial_placement;
        cmd.current_runnable = i_current_runnable;
        unique case (i_opcode)
            OP_ENQ:    cmd.kind = in_range ? K_ENQ : K_NOP;
            OP_DEQ:    cmd.kind = in_range ? K_DEQ : K_NOP;
            OP_PLACE:  cmd.kind = in_range ? K_PLACE : K_NOP;
            OP_PICK:   cmd.kind = K_PICK;
            OP_CHARGE: cmd.kind = K_CHARGE;
            OP_SLICE:  cmd.kind = K_SLICE;
            default:   cmd.kind = K_NOP;
        endcase
    end

    assign o_stall = (r_cnt == 2'(DEPTH));
    assign push = i_valid && !o_stall;
    assign o_head = r_q[r_rptr];
    assign o_head_valid = (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd;
        end
    end

endmodule

[rtl/vrfs_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrfs_div #(
    parameter int N_W = 37,
    parameter int D_W = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_busy,
    output logic [N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [D_W:0]     cat;
    logic [D_W:0]     trial;
    logic             ge;

    // One trial subtraction per step.
    always_comb begin
        cat = {r_rem, r_quo[N_W-1]};
        trial = cat - {1'b0, r_div};
        ge = (cat >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CNT_W'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? trial[D_W-1:0] : cat[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quotient = r_quo;

endmodule

[rtl/vrfs_engine.sv]
// ----------------------------------------------------------------------------
// Scheduler engine
// Executes classified commands against the task table and registers results.
// ----------------------------------------------------------------------------
module vrfs_engine import vrfs_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_head,
    input  logic    i_head_valid,
    output logic    o_pop,
    input  t_cfg    i_cfg,
    input  logic    i_out_stall,
    output t_result o_res,
    output logic    o_res_valid
);

    localparam int TW = $clog2(NUM_TASKS);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EXEC      = 4'd1;
    localparam logic [3:0] S_SCAN      = 4'd2;
    localparam logic [3:0] S_SCAN_END  = 4'd3;
    localparam logic [3:0] S_PICK_FIN  = 4'd4;
    localparam logic [3:0] S_CHG_EXEC  = 4'd5;
    localparam logic [3:0] S_CHG_CAND  = 4'd6;
    localparam logic [3:0] S_CHG_FIN   = 4'd7;
    localparam logic [3:0] S_SLC_MUL   = 4'd8;
    localparam logic [3:0] S_SLC_START = 4'd9;
    localparam logic [3:0] S_SLC_WAIT  = 4'd10;

    // Control state.
    logic [3:0]         r_state, n_state;
    logic [NUM_TASKS-1:0] r_queued, n_queued;
    logic [NUM_TASKS-1:0] r_vvalid, n_vvalid;
    logic [NUM_TASKS-1:0] r_rvalid, n_rvalid;
    logic [SEQ_W-1:0]   r_ins_cnt, n_ins_cnt;
    logic               r_cur_valid, n_cur_valid;
    logic [TW-1:0]      r_cur_task, n_cur_task;
    logic [TIME_W-1:0]  r_start, n_start;
    logic [TIME_W-1:0]  r_floor, n_floor;
    logic [COUNT_W-1:0] r_wc, n_wc;
    logic               r_pend, n_pend;
    logic               r_found, n_found;
    logic               r_res_valid;

    // Working registers.
    logic [2:0]         r_kind, n_kind;
    logic [TW-1:0]      r_slot, n_slot;
    logic [TIME_W-1:0]  r_now, n_now;
    logic               r_init, n_init;
    logic               r_run, n_run;
    logic [TIME_W-1:0]  r_delta, n_delta;
    logic [TW-1:0]      r_idx, n_idx;
    logic [TW-1:0]      r_rd_idx;
    logic [TW-1:0]      r_best_idx, n_best_idx;
    logic [TIME_W-1:0]  r_best_vr, n_best_vr;
    logic [SEQ_W-1:0]   r_best_seq, n_best_seq;
    logic [TIME_W-1:0]  r_cur_vr, n_cur_vr;
    logic [TIME_W-1:0]  r_cand, n_cand;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [COUNT_W-1:0] r_n, n_n;
    t_result            r_res, n_res;
    logic               res_load;

    // Memory ports.
    logic [TW-1:0]      rd_addr;
    logic               vr_we, rt_we, seq_we;
    logic [TW-1:0]      vr_waddr;
    logic [TIME_W-1:0]  vr_wdata, rt_wdata;
    logic [TIME_W-1:0]  vr_q, rt_q, vr_eff, rt_eff;
    logic [SEQ_W-1:0]   seq_q;

    // Divider and misc.
    logic               div_start, div_busy;
    logic [PERIOD_W-1:0] div_q;
    logic               out_free;
    logic [TW-1:0]      head_slot;
    logic [TIME_W-1:0]  place_v;
    logic [PERIOD_W-1:0] prod;
    logic [COUNT_W-1:0] cnt_n;
    logic               take;

    vrfs_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TASKS)) u_vr_ram (
        .i_clk(i_clk), .i_we(vr_we), .i_waddr(vr_waddr), .i_wdata(vr_wdata),
        .i_raddr(rd_addr), .o_rdata(vr_q)
    );

    vrfs_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TASKS)) u_rt_ram (
        .i_clk(i_clk), .i_we(rt_we), .i_waddr(r_slot), .i_wdata(rt_wdata),
        .i_raddr(rd_addr), .o_rdata(rt_q)
    );

    vrfs_ram #(.WIDTH(SEQ_W), .DEPTH(NUM_TASKS)) u_seq_ram (
        .i_clk(i_clk), .i_we(seq_we), .i_waddr(r_slot), .i_wdata(r_ins_cnt),
        .i_raddr(rd_addr), .o_rdata(seq_q)
    );

    vrfs_div #(.N_W(PERIOD_W), .D_W(COUNT_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_period), .i_divisor(r_n),
        .o_busy(div_busy), .o_quotient(div_q)
    );

    assign out_free = !r_res_valid || !i_out_stall;
    assign head_slot = TW'(i_head.tid);

    // Read address: the addressed slot on dispatch and while it executes,
    // the scan index otherwise.
    always_comb begin
        if (r_state == S_IDLE) begin
            rd_addr = (i_head.kind == K_CHARGE) ? r_cur_task : head_slot;
        end else if (r_state == S_EXEC) begin
            rd_addr = r_slot;
        end else begin
            rd_addr = r_idx;
        end
    end

    // Entries never written read as zero.
    assign vr_eff = r_vvalid[r_rd_idx] ? vr_q : '0;
    assign rt_eff = r_rvalid[r_rd_idx] ? rt_q : '0;

    assign cnt_n = r_wc + COUNT_W'(1);
    assign prod = {{COUNT_W{1'b0}}, i_cfg.min_granularity_ns} * {{NS_W{1'b0}}, cnt_n};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_queued = r_queued;
        n_vvalid = r_vvalid;
        n_rvalid = r_rvalid;
        n_ins_cnt = r_ins_cnt;
        n_cur_valid = r_cur_valid;
        n_cur_task = r_cur_task;
        n_start = r_start;
        n_floor = r_floor;
        n_wc = r_wc;
        n_pend = r_pend;
        n_found = r_found;
        n_kind = r_kind;
        n_slot = r_slot;
        n_now = r_now;
        n_init = r_init;
        n_run = r_run;
        n_delta = r_delta;
        n_idx = r_idx;
        n_best_idx = r_best_idx;
        n_best_vr = r_best_vr;
        n_best_seq = r_best_seq;
        n_cur_vr = r_cur_vr;
        n_cand = r_cand;
        n_period = r_period;
        n_n = r_n;
        o_pop = 1'b0;
        vr_we = 1'b0;
        rt_we = 1'b0;
        seq_we = 1'b0;
        vr_waddr = r_slot;
        vr_wdata = '0;
        rt_wdata = rt_eff + r_delta;
        div_start = 1'b0;
        res_load = 1'b0;
        place_v = r_floor - (r_init ? '0 : TIME_W'(i_cfg.latency_ns));
        take = 1'b0;
        n_res.status = ST_NOEFF;
        n_res.picked_valid = 1'b0;
        n_res.picked_task = '0;
        n_res.task_vruntime = '0;
        n_res.slice_ns = '0;

        // Compare stage of the scan over the vruntime and stamp memories.
        if ((r_state == S_SCAN || r_state == S_SCAN_END) && r_pend) begin
            if (r_queued[r_rd_idx]) begin
                take = !r_found || vr_before(vr_eff, r_best_vr) ||
                       (vr_eff == r_best_vr && seq_before(seq_q, r_best_seq));
            end
            if (take) begin
                n_found = 1'b1;
                n_best_idx = r_rd_idx;
                n_best_vr = vr_eff;
                n_best_seq = seq_q;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    n_kind = i_head.kind;
                    if (i_head.kind == K_CHARGE && !r_cur_valid) begin
                        n_kind = K_NOP;
                    end
                    n_slot = (i_head.kind == K_CHARGE) ? r_cur_task : head_slot;
                    n_now = i_head.now_ns;
                    n_init = i_head.initial_placement;
                    n_run = i_head.current_runnable;
                    n_delta = i_head.now_ns - r_start;
                    n_found = 1'b0;
                    n_pend = 1'b0;
                    n_idx = '0;
                    if (i_head.kind == K_PICK) begin
                        n_state = S_SCAN;
                    end else if (i_head.kind == K_CHARGE && r_cur_valid) begin
                        n_state = S_CHG_EXEC;
                    end else if (i_head.kind == K_SLICE) begin
                        n_state = S_SLC_MUL;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    res_load = 1'b1;
                    n_state = S_IDLE;
                    n_res.task_vruntime = vr_eff;
                    case (r_kind)
                        K_ENQ: begin
                            if (!r_queued[r_slot]) begin
                                n_queued[r_slot] = 1'b1;
                                seq_we = 1'b1;
                                n_ins_cnt = r_ins_cnt + SEQ_W'(1);
                                n_wc = r_wc + COUNT_W'(1);
                                n_res.status = ST_DONE;
                            end
                        end
                        K_DEQ: begin
                            if (r_queued[r_slot]) begin
                                n_queued[r_slot] = 1'b0;
                                n_wc = r_wc - COUNT_W'(1);
                                n_res.status = ST_DONE;
                            end
                        end
                        K_PLACE: begin
                            if (vr_before(vr_eff, place_v)) begin
                                vr_we = 1'b1;
                                vr_wdata = place_v;
                                n_vvalid[r_slot] = 1'b1;
                                n_res.task_vruntime = place_v;
                                n_res.status = ST_DONE;
                            end
                        end
                        default: begin
                            n_res.task_vruntime = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_pend = 1'b1;
                if (r_idx == TW'(NUM_TASKS - 1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + TW'(1);
                end
            end
            S_SCAN_END: begin
                n_pend = 1'b0;
                n_state = (r_kind == K_PICK) ? S_PICK_FIN : S_CHG_CAND;
            end
            S_PICK_FIN: begin
                if (out_free) begin
                    res_load = 1'b1;
                    n_state = S_IDLE;
                    if (!r_found) begin
                        n_cur_valid = 1'b0;
                        n_res.status = ST_EMPTY;
                    end else begin
                        n_queued[r_best_idx] = 1'b0;
                        n_wc = r_wc - COUNT_W'(1);
                        n_cur_valid = 1'b1;
                        n_cur_task = r_best_idx;
                        n_start = r_now;
                        n_res.status = ST_DONE;
                        n_res.picked_valid = 1'b1;
                        n_res.picked_task = TID_W'(r_best_idx);
                        n_res.task_vruntime = r_best_vr;
                    end
                end
            end
            S_CHG_EXEC: begin
                // Add the elapsed time to vruntime and runtime, then scan.
                vr_we = 1'b1;
                vr_waddr = r_slot;
                vr_wdata = vr_eff + r_delta;
                rt_we = 1'b1;
                n_vvalid[r_slot] = 1'b1;
                n_rvalid[r_slot] = 1'b1;
                n_cur_vr = vr_eff + r_delta;
                n_start = r_now;
                n_found = 1'b0;
                n_pend = 1'b0;
                n_idx = '0;
                n_state = S_SCAN;
            end
            S_CHG_CAND: begin
                n_cand = r_run ? r_cur_vr : r_floor;
                if (r_found) begin
                    if (!r_run || vr_before(r_best_vr, r_cur_vr)) begin
                        n_cand = r_best_vr;
                    end
                end
                n_state = S_CHG_FIN;
            end
            S_CHG_FIN: begin
                if (out_free) begin
                    res_load = 1'b1;
                    n_state = S_IDLE;
                    if (vr_before(r_floor, r_cand)) begin
                        n_floor = r_cand;
                    end
                    n_res.status = ST_DONE;
                    n_res.task_vruntime = r_cur_vr;
                end
            end
            S_SLC_MUL: begin
                n_n = cnt_n;
                n_period = (cnt_n > i_cfg.latency_task_limit) ? prod
                                                             : PERIOD_W'(i_cfg.latency_ns);
                n_state = S_SLC_START;
            end
            S_SLC_START: begin
                div_start = 1'b1;
                n_state = S_SLC_WAIT;
            end
            S_SLC_WAIT: begin
                if (!div_busy && out_free) begin
                    res_load = 1'b1;
                    n_state = S_IDLE;
                    n_res.status = ST_DONE;
                    n_res.slice_ns = div_q[NS_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.floor_vruntime = n_floor;
        n_res.queued_count = n_wc;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_queued <= '0;
            r_vvalid <= '0;
            r_rvalid <= '0;
            r_ins_cnt <= '0;
            r_cur_valid <= 1'b0;
            r_cur_task <= '0;
            r_start <= '0;
            r_floor <= '0;
            r_wc <= '0;
            r_pend <= 1'b0;
            r_found <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_queued <= n_queued;
            r_vvalid <= n_vvalid;
            r_rvalid <= n_rvalid;
            r_ins_cnt <= n_ins_cnt;
            r_cur_valid <= n_cur_valid;
            r_cur_task <= n_cur_task;
            r_start <= n_start;
            r_floor <= n_floor;
            r_wc <= n_wc;
            r_pend <= n_pend;
            r_found <= n_found;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_slot <= n_slot;
        r_now <= n_now;
        r_init <= n_init;
        r_run <= n_run;
        r_delta <= n_delta;
        r_idx <= n_idx;
        r_rd_idx <= rd_addr;
        r_best_idx <= n_best_idx;
        r_best_vr <= n_best_vr;
        r_best_seq <= n_best_seq;
        r_cur_vr <= n_cur_vr;
        r_cand <= n_cand;
        r_period <= n_period;
        r_n <= n_n;
        if (res_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
    assign o_res_valid = r_res_valid;

endmodule

[rtl/vrfs_checker.sv]
// ----------------------------------------------------------------------------
// Scheduler port checker
// Concurrent assertions on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module vrfs_checker import vrfs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [OPCODE_W-1:0]   i_opcode,
    input logic [TID_W-1:0]      i_task_id,
    input logic [TIME_W-1:0]     i_now_ns,
    input logic                  i_initial_placement,
    input logic                  i_current_runnable,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [STATUS_W-1:0]   o_status,
    input logic                  o_picked_valid,
    input logic [TID_W-1:0]      o_picked_task,
    input logic [TIME_W-1:0]     o_task_vruntime,
    input logic [TIME_W-1:0]     o_floor_vruntime,
    input logic [COUNT_W-1:0]    o_queued_count,
    input logic [NS_W-1:0]       o_slice_ns,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A picked task always comes with a done status.
    a_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_picked_valid |-> o_status == ST_DONE)
        else $error("picked task without done status");

    // An empty pick reports no task and no vruntime.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> !o_picked_valid && o_task_vruntime == '0)
        else $error("empty pick reported a task");

    // A slice value only appears on a completed transaction.
    a_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_slice_ns != '0 |-> o_status == ST_DONE && !o_picked_valid)
        else $error("slice value on wrong transaction");

    // The run queue never exceeds the task ids that can address it.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_queued_count <= COUNT_W'(64))
        else $error("queued count out of range");

endmodule

bind virtual_runtime_fair_scheduler vrfs_checker u_vrfs_checker (.*);
